FILE: src/seconds_to_calendar_ascii_assert.svh
// assertion macros used by the calendar converter checker
`ifndef SECONDS_TO_CALENDAR_ASCII_ASSERT_SVH
`define SECONDS_TO_CALENDAR_ASCII_ASSERT_SVH

// clocked assertion, quiet while reset is high
`define S2CAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define S2CAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/s2cal_pkg.sv
// shared constants, types and tables of the calendar converter
`timescale 1ns / 1ps
package s2cal_pkg;

  typedef logic [6:0] letter_t;
  typedef logic [5:0] digit_char_t;
  typedef logic [3:0] month_idx_t;

  localparam int MONTHS = 12;

  // reciprocal for unsigned divide by 60 over 32 bits: (x * M) >> 37
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int DIV60_SHIFT = 37;
  // reciprocal for unsigned divide by 3 over 32 bits: (x * M) >> 33
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
  localparam int DIV3_SHIFT = 33;
  // reciprocal for divide by 365, exact for 16-bit day counts
  localparam logic [15:0] DIV365_MAGIC = 16'd45965;
  localparam int DIV365_SHIFT = 24;

  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam digit_char_t ASCII_ZERO = 6'h30;

  // first day of year of each month, non-leap
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // three-letter month abbreviation, first letter in the top bits
  function automatic logic [20:0] month_text(input month_idx_t m);
    case (m)
      4'd0:  return {7'h4A, 7'h41, 7'h4E};
      4'd1:  return {7'h46, 7'h45, 7'h42};
      4'd2:  return {7'h4D, 7'h41, 7'h52};
      4'd3:  return {7'h41, 7'h50, 7'h52};
      4'd4:  return {7'h4D, 7'h41, 7'h59};
      4'd5:  return {7'h4A, 7'h55, 7'h4E};
      4'd6:  return {7'h4A, 7'h55, 7'h4C};
      4'd7:  return {7'h41, 7'h55, 7'h47};
      4'd8:  return {7'h53, 7'h45, 7'h50};
      4'd9:  return {7'h4F, 7'h43, 7'h54};
      4'd10: return {7'h4E, 7'h4F, 7'h56};
      default: return {7'h44, 7'h45, 7'h43};
    endcase
  endfunction

endpackage

FILE: src/s2cal_digits.sv
// splits a value below 64 into two ascii decimal digits
`timescale 1ns / 1ps
module s2cal_digits (
  input  logic [5:0]            value,
  output s2cal_pkg::digit_char_t tens_char,
  output s2cal_pkg::digit_char_t ones_char
);
  import s2cal_pkg::*;

  logic [13:0] recip;
  logic [2:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  ones;

  // v / 10 as (v * 205) >> 11, exact far past 63
  assign recip    = {8'b0, value} * 14'd205;
  assign tens     = recip[13:11];
  assign tens_x10 = {4'b0, tens} * 7'd10;
  assign ones     = 4'(value - tens_x10[5:0]);

  assign tens_char = ASCII_ZERO + {3'b0, tens};
  assign ones_char = ASCII_ZERO + {2'b0, ones};

endmodule

FILE: src/seconds_to_calendar_ascii.sv
// elapsed seconds to month name, day, hour, minute and second in ascii
//
//   channel    signals                            direction  beat
//   seconds    seconds_valid / seconds_stall      in         one 32-bit count
//   calendar   calendar_valid / calendar_stall    out        one timestamp
//
// seven register stages; one beat accepted per cycle unless seconds_stall is
// high. the stages hold the chain of four reciprocal multiplies (by 1/60,
// 1/60, 1/3 after a divide by 8, and 1/365), one to a stage, then day of
// year, month lookup and digit split. synchronous reset clears the stage
// valid bits only; no memory, so no clearing pass. a stall on the calendar
// side holds each full stage with only full stages ahead of it; the others move up into the gaps.
`timescale 1ns / 1ps
module seconds_to_calendar_ascii (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   seconds_valid,
  output logic                   seconds_stall,
  input  logic [31:0]            elapsed_seconds,
  output logic                   calendar_valid,
  input  logic                   calendar_stall,
  output s2cal_pkg::letter_t     month_letter_first,
  output s2cal_pkg::letter_t     month_letter_second,
  output s2cal_pkg::letter_t     month_letter_third,
  output s2cal_pkg::digit_char_t day_tens_char,
  output s2cal_pkg::digit_char_t day_ones_char,
  output s2cal_pkg::digit_char_t hour_tens_char,
  output s2cal_pkg::digit_char_t hour_ones_char,
  output s2cal_pkg::digit_char_t minute_tens_char,
  output s2cal_pkg::digit_char_t minute_ones_char,
  output s2cal_pkg::digit_char_t second_tens_char,
  output s2cal_pkg::digit_char_t second_ones_char
);
  import s2cal_pkg::*;

  // stage valid bits and enables; a stage loads when empty or when the
  // stage after it moves
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !v7 || !calendar_stall;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign seconds_stall  = !en1;
  assign calendar_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en1) v1 <= seconds_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 1: total minutes = t / 60, keep low bits of t for the seconds
  logic [63:0] prod1;
  logic [26:0] s1_min_total;
  logic [5:0]  s1_t_lo;

  assign prod1 = 64'(elapsed_seconds) * 64'(DIV60_MAGIC);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_min_total <= prod1[DIV60_SHIFT +: 27];
      s1_t_lo      <= elapsed_seconds[5:0];
    end
  end

  // stage 2: seconds by subtraction (mod 64 is enough), total hours = min / 60
  logic [63:0] prod2;
  logic [11:0] s1_min_x60;
  logic [20:0] s2_hour_total;
  logic [5:0]  s2_min_lo;
  logic [5:0]  s2_sec;

  assign prod2      = 64'(s1_min_total) * 64'(DIV60_MAGIC);
  assign s1_min_x60 = {6'b0, s1_min_total[5:0]} * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_hour_total <= prod2[DIV60_SHIFT +: 21];
      s2_min_lo     <= s1_min_total[5:0];
      s2_sec        <= s1_t_lo - s1_min_x60[5:0];
    end
  end

  // stage 3: minutes by subtraction, days = (hours / 8) / 3
  logic [63:0] prod3;
  logic [11:0] s2_hour_x60;
  logic [15:0] s3_days;
  logic [4:0]  s3_hour_lo;
  logic [5:0]  s3_min;
  logic [5:0]  s3_sec;

  assign prod3       = 64'(s2_hour_total[20:3]) * 64'(DIV3_MAGIC);
  assign s2_hour_x60 = {6'b0, s2_hour_total[5:0]} * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_days    <= prod3[DIV3_SHIFT +: 16];
      s3_hour_lo <= s2_hour_total[4:0];
      s3_min     <= s2_min_lo - s2_hour_x60[5:0];
      s3_sec     <= s2_sec;
    end
  end

  // stage 4: hour of day by subtraction, years = days / 365
  logic [31:0] prod4;
  logic [9:0]  s3_days_x24;
  logic [7:0]  s4_years;
  logic [8:0]  s4_days_lo;
  logic [4:0]  s4_hour;
  logic [5:0]  s4_min;
  logic [5:0]  s4_sec;

  assign prod4       = 32'(s3_days) * 32'(DIV365_MAGIC);
  assign s3_days_x24 = {5'b0, s3_days[4:0]} * 10'(HOURS_PER_DAY);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_years   <= prod4[DIV365_SHIFT +: 8];
      s4_days_lo <= s3_days[8:0];
      s4_hour    <= s3_hour_lo - s3_days_x24[4:0];
      s4_min     <= s3_min;
      s4_sec     <= s3_sec;
    end
  end

  // stage 5: day of year, which wraps every 365 days
  logic [16:0] s4_years_x365;
  logic [8:0]  s5_doy;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_min;
  logic [5:0]  s5_sec;

  assign s4_years_x365 = {9'b0, s4_years} * 17'(DAYS_PER_YEAR);

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_doy  <= s4_days_lo - s4_years_x365[8:0];
      s5_hour <= s4_hour;
      s5_min  <= s4_min;
      s5_sec  <= s4_sec;
    end
  end

  // stage 6: month is the last boundary at or below the day of year
  month_idx_t month_sel;
  logic [8:0] dom_wide;
  month_idx_t s6_month;
  logic [4:0] s6_dom;
  logic [4:0] s6_hour;
  logic [5:0] s6_min;
  logic [5:0] s6_sec;

  always_comb begin
    month_sel = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (s5_doy >= MONTH_START[i]) month_sel = month_idx_t'(i);
    end
  end

  assign dom_wide = s5_doy - MONTH_START[month_sel] + 9'd1;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_month <= month_sel;
      s6_dom   <= dom_wide[4:0];
      s6_hour  <= s5_hour;
      s6_min   <= s5_min;
      s6_sec   <= s5_sec;
    end
  end

  // stage 7: month letters and ascii digits into the output register
  logic [20:0] name;
  digit_char_t day_t, day_o, hour_t, hour_o, min_t, min_o, sec_t, sec_o;

  assign name = month_text(s6_month);

  s2cal_digits u_day  (.value({1'b0, s6_dom}),  .tens_char(day_t),  .ones_char(day_o));
  s2cal_digits u_hour (.value({1'b0, s6_hour}), .tens_char(hour_t), .ones_char(hour_o));
  s2cal_digits u_min  (.value(s6_min),          .tens_char(min_t),  .ones_char(min_o));
  s2cal_digits u_sec  (.value(s6_sec),          .tens_char(sec_t),  .ones_char(sec_o));

  always_ff @(posedge clk) begin
    if (en7) begin
      month_letter_first  <= name[20:14];
      month_letter_second <= name[13:7];
      month_letter_third  <= name[6:0];
      day_tens_char       <= day_t;
      day_ones_char       <= day_o;
      hour_tens_char      <= hour_t;
      hour_ones_char      <= hour_o;
      minute_tens_char    <= min_t;
      minute_ones_char    <= min_o;
      second_tens_char    <= sec_t;
      second_ones_char    <= sec_o;
    end
  end

endmodule

FILE: src/s2cal_sva.sv
// port-level checks of the calendar converter and their bind
`timescale 1ns / 1ps
`include "seconds_to_calendar_ascii_assert.svh"
module s2cal_sva (
  input logic                   clk,
  input logic                   rst,
  input logic                   seconds_valid,
  input logic                   seconds_stall,
  input logic [31:0]            elapsed_seconds,
  input logic                   calendar_valid,
  input logic                   calendar_stall,
  input s2cal_pkg::letter_t     month_letter_first,
  input s2cal_pkg::letter_t     month_letter_second,
  input s2cal_pkg::letter_t     month_letter_third,
  input s2cal_pkg::digit_char_t day_tens_char,
  input s2cal_pkg::digit_char_t day_ones_char,
  input s2cal_pkg::digit_char_t hour_tens_char,
  input s2cal_pkg::digit_char_t hour_ones_char,
  input s2cal_pkg::digit_char_t minute_tens_char,
  input s2cal_pkg::digit_char_t minute_ones_char,
  input s2cal_pkg::digit_char_t second_tens_char,
  input s2cal_pkg::digit_char_t second_ones_char
);
  import s2cal_pkg::*;

  // whole result beat, a stalled beat and the hour and digit limits
  logic [68:0] stamp;
  logic        held;
  logic        hour_top;
  logic        digits_ok;

  assign stamp = {month_letter_first, month_letter_second, month_letter_third,
                  day_tens_char, day_ones_char, hour_tens_char, hour_ones_char,
                  minute_tens_char, minute_ones_char, second_tens_char,
                  second_ones_char};
  assign held      = calendar_valid && calendar_stall;
  assign hour_top  = calendar_valid && hour_tens_char == 6'h32;
  assign digits_ok = minute_tens_char <= 6'h35 && second_tens_char <= 6'h35 &&
                     (day_tens_char != 6'h33 || day_ones_char <= 6'h31);

  // a stalled result beat keeps its timestamp
  `S2CAL_ASSERT(a_hold, held |=> calendar_valid && $stable(stamp), "stalled result changed")

  // pipeline is empty right after reset
  `S2CAL_ASSERT_ALWAYS(a_reset_empty, rst |=> !calendar_valid, "result valid after reset")

  // hours never pass 23
  `S2CAL_ASSERT(a_hour_range, hour_top |-> hour_ones_char <= 6'h33, "hour above 23")

  // minutes and seconds stay below 60, day of month below 32
  `S2CAL_ASSERT(a_digit_range, calendar_valid |-> digits_ok, "digit out of range")

endmodule

bind seconds_to_calendar_ascii s2cal_sva u_s2cal_sva (.*);

FILE: bench/seconds_to_calendar_ascii_test.sv
// self-checking bench for the elapsed-seconds to calendar ascii converter
`timescale 1ns / 1ps
module seconds_to_calendar_ascii_test;
  import s2cal_pkg::*;

  // run shape
  localparam int RANDOM_COUNTS = 1250;
  localparam int MAX_IDLE      = 16;    // per-beat gap or stall, in cycles
  localparam int LONG_HOLD     = 300;   // one long receiver hold-off
  localparam int HOLD_AT       = 400;   // random beat that asks for the hold-off
  localparam int PAUSE_AT      = 800;   // random beat after which the sender drains
  localparam int DRAIN_CYCLES  = 24;    // extra wait, well past the seven stages
  localparam int STALL_LIMIT   = 4000;  // cycles with no beat on either side

  localparam int SECS_MINUTE = 60;
  localparam int SECS_HOUR   = 3600;
  localparam int SECS_DAY    = 86400;
  localparam int YEAR_DAYS   = 365;
  localparam int YEAR_SECS   = 31536000;
  localparam int CHAR_ZERO   = 48;

  // day of year on which each month of a non-leap year starts
  localparam int unsigned FIRST_DAY [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  // month abbreviations back to back, january in the top bytes
  localparam logic [8*36-1:0] MONTH_NAMES = "JANFEBMARAPRMAYJUNJULAUGSEPOCTNOVDEC";

  // one calendar beat as it leaves the block
  typedef struct packed {
    letter_t     month_first;
    letter_t     month_second;
    letter_t     month_third;
    digit_char_t day_tens;
    digit_char_t day_ones;
    digit_char_t hour_tens;
    digit_char_t hour_ones;
    digit_char_t minute_tens;
    digit_char_t minute_ones;
    digit_char_t second_tens;
    digit_char_t second_ones;
  } stamp_t;

  // directed counts; a text entry is the stamp typed in by hand,
  // an empty one leaves the row to the predictor
  localparam int PLAN_ROWS = 24;
  localparam logic [31:0] PLAN_SECS [PLAN_ROWS] = '{
    32'd0,        32'd59,       32'd60,       32'd3599,
    32'd3600,     32'd86399,    32'd86400,    32'd2678399,
    32'd2678400,  32'd5097599,  32'd5097600,  32'd7776000,
    32'd10368000, 32'd13046400, 32'd15638400, 32'd18316800,
    32'd20995200, 32'd23587200, 32'd26265600, 32'd28857600,
    32'd31535999, 32'd31536000, 32'hFFFF_FFFF, 32'h8000_0000
  };
  string plan_text [PLAN_ROWS] = '{
    "JAN01000000", "JAN01000059", "JAN01000100", "JAN01005959",
    "JAN01010000", "JAN01235959", "JAN02000000", "",
    "",            "",            "",            "",
    "",            "",            "",            "",
    "",            "",            "",            "",
    "DEC31235959", "JAN01000000", "MAR12062815", ""
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seconds_valid = 1'b0;
  logic        seconds_stall;
  logic [31:0] elapsed_seconds = '0;
  logic        calendar_valid;
  logic        calendar_stall = 1'b0;
  letter_t     month_letter_first;
  letter_t     month_letter_second;
  letter_t     month_letter_third;
  digit_char_t day_tens_char;
  digit_char_t day_ones_char;
  digit_char_t hour_tens_char;
  digit_char_t hour_ones_char;
  digit_char_t minute_tens_char;
  digit_char_t minute_ones_char;
  digit_char_t second_tens_char;
  digit_char_t second_ones_char;

  // expectation riding along with the offered count, same edge as the payload
  stamp_t offered_stamp = '0;
  stamp_t stamps_due [$];
  int     mismatches = 0;

  // handshake between sender and receiver for the long hold-off
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  seconds_to_calendar_ascii dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic digit_char_t tens_char(input int unsigned v);
    return digit_char_t'(CHAR_ZERO + (v / 10) % 10);
  endfunction

  function automatic digit_char_t ones_char(input int unsigned v);
    return digit_char_t'(CHAR_ZERO + v % 10);
  endfunction

  // calendar stamp a count of elapsed seconds should read as
  function automatic stamp_t calendar_of(input logic [31:0] secs);
    int unsigned t;
    int unsigned yday;
    int unsigned mon;
    int          i;
    stamp_t      s;
    t = secs;
    yday = (t / SECS_DAY) % YEAR_DAYS;
    mon = 0;
    for (i = 1; i < 12; i++) begin
      if (yday >= FIRST_DAY[i]) mon = i;
    end
    s.month_first  = letter_t'(MONTH_NAMES[8*(35 - 3*mon) +: 8]);
    s.month_second = letter_t'(MONTH_NAMES[8*(34 - 3*mon) +: 8]);
    s.month_third  = letter_t'(MONTH_NAMES[8*(33 - 3*mon) +: 8]);
    s.day_tens     = tens_char(yday - FIRST_DAY[mon] + 1);
    s.day_ones     = ones_char(yday - FIRST_DAY[mon] + 1);
    s.hour_tens    = tens_char((t / SECS_HOUR) % 24);
    s.hour_ones    = ones_char((t / SECS_HOUR) % 24);
    s.minute_tens  = tens_char((t / SECS_MINUTE) % 60);
    s.minute_ones  = ones_char((t / SECS_MINUTE) % 60);
    s.second_tens  = tens_char(t % SECS_MINUTE);
    s.second_ones  = ones_char(t % SECS_MINUTE);
    return s;
  endfunction

  // hand-typed stamp, "MMMDDhhmmss"
  function automatic stamp_t stamp_of_text(input string txt);
    stamp_t s;
    s.month_first  = letter_t'(txt[0]);
    s.month_second = letter_t'(txt[1]);
    s.month_third  = letter_t'(txt[2]);
    s.day_tens     = digit_char_t'(txt[3]);
    s.day_ones     = digit_char_t'(txt[4]);
    s.hour_tens    = digit_char_t'(txt[5]);
    s.hour_ones    = digit_char_t'(txt[6]);
    s.minute_tens  = digit_char_t'(txt[7]);
    s.minute_ones  = digit_char_t'(txt[8]);
    s.second_tens  = digit_char_t'(txt[9]);
    s.second_ones  = digit_char_t'(txt[10]);
    return s;
  endfunction

  // random count: full range, first year, or a second or two around a month start
  function automatic logic [31:0] pick_count();
    int unsigned kind;
    int unsigned year;
    int unsigned mon;
    int unsigned delta;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom();
    if (kind < 7) return $urandom_range(0, YEAR_SECS - 1);
    year  = $urandom_range(0, 135);    // keeps the count inside 32 bits
    mon   = $urandom_range(0, 11);
    delta = $urandom_range(0, 4);
    // wraps below zero on purpose: still a legal count
    return 32'((year * YEAR_DAYS + FIRST_DAY[mon]) * SECS_DAY + delta - 2);
  endfunction

  task automatic check_char(input string name, input logic [6:0] want, input logic [6:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d ('%c') got %0d ('%c')",
               $time, name, want, want, got, got);
    end
  endtask

  // offer one count after an idle gap, hold it until taken
  task automatic offer_count(input logic [31:0] secs, input stamp_t want, input int gap);
    if (gap > 0) begin
      seconds_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seconds_valid   <= 1'b1;
    elapsed_seconds <= secs;
    offered_stamp   <= want;
    do @(posedge clk); while (seconds_stall !== 1'b0);
  endtask

  // stop offering and wait until every expected beat has come back
  task automatic wait_drained();
    seconds_valid <= 1'b0;
    @(posedge clk);    // the last push lands on the edge the count was taken
    while (stamps_due.size() != 0) @(posedge clk);
  endtask

  // scoreboard: push on each count beat, compare on each calendar beat
  always @(posedge clk) begin : scoreboard
    stamp_t want;
    if (!rst) begin
      if (seconds_valid === 1'b1 && seconds_stall === 1'b0) stamps_due.push_back(offered_stamp);
      if (calendar_valid === 1'b1 && calendar_stall === 1'b0) begin
        if (stamps_due.size() == 0) begin
          mismatches++;
          $display("%0t: calendar beat with nothing expected", $time);
        end else begin
          want = stamps_due.pop_front();
          check_char("month_letter_first", want.month_first, month_letter_first);
          check_char("month_letter_second", want.month_second, month_letter_second);
          check_char("month_letter_third", want.month_third, month_letter_third);
          check_char("day_tens_char", {1'b0, want.day_tens}, {1'b0, day_tens_char});
          check_char("day_ones_char", {1'b0, want.day_ones}, {1'b0, day_ones_char});
          check_char("hour_tens_char", {1'b0, want.hour_tens}, {1'b0, hour_tens_char});
          check_char("hour_ones_char", {1'b0, want.hour_ones}, {1'b0, hour_ones_char});
          check_char("minute_tens_char", {1'b0, want.minute_tens},
                     {1'b0, minute_tens_char});
          check_char("minute_ones_char", {1'b0, want.minute_ones},
                     {1'b0, minute_ones_char});
          check_char("second_tens_char", {1'b0, want.second_tens},
                     {1'b0, second_tens_char});
          check_char("second_ones_char", {1'b0, want.second_ones},
                     {1'b0, second_ones_char});
        end
      end
    end
  end

  // receiver: random stall before each calendar beat, calm stretches, one long hold
  initial begin : receiver
    int pause;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    forever begin
      if (hold_request) begin
        // hold off long enough that the stages fill and the input stalls
        hold_request = 1'b0;
        hold_active = 1'b1;
        calendar_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        calendar_stall <= 1'b0;
        hold_active = 1'b0;
      end else begin
        pause = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (pause > 0) begin
          calendar_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          calendar_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(calendar_valid === 1'b1 && calendar_stall === 1'b0));
      taken++;
      if (taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
    end
  end

  // watchdog: too long without a beat on either side ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((seconds_valid === 1'b1 && seconds_stall === 1'b0) ||
          (calendar_valid === 1'b1 && calendar_stall === 1'b0)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // sender: directed table, then random counts with gaps and bursts
  initial begin : sender
    int  i;
    int  gap;
    bit  calm;
    logic [31:0] secs;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PLAN_ROWS; i++) begin
      offer_count(PLAN_SECS[i],
                  (plan_text[i] == "") ? calendar_of(PLAN_SECS[i]) : stamp_of_text(plan_text[i]),
                  $urandom_range(0, MAX_IDLE));
    end
    wait_drained();

    for (i = 0; i < RANDOM_COUNTS; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (i == HOLD_AT) hold_request = 1'b1;
      // back-to-back beats while the receiver is held off
      gap = (calm || hold_request || hold_active) ? 0 : $urandom_range(0, MAX_IDLE);
      secs = pick_count();
      offer_count(secs, calendar_of(secs), gap);
      if (i == PAUSE_AT) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && stamps_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
